[src/lrb_pkg.sv]
`default_nettype none

package lrb_pkg;

  // Field widths.
  localparam int CNT_W   = 32;
  localparam int IVL_W   = 16;
  localparam int TALLY_W = 8;
  localparam int CFG_IDX_W = 3;
  localparam int REM_CNT_W = $clog2(CNT_W);

  localparam logic [TALLY_W-1:0] TALLY_MAX = {TALLY_W{1'b1}};

  // Supervisor steps.
  typedef enum logic [2:0] {
    STEP_INIT   = 3'd0,
    STEP_GETKEY = 3'd1,
    STEP_KEYOK  = 3'd2,
    STEP_CHECK  = 3'd3,
    STEP_RETRY1 = 3'd4,
    STEP_RETRY2 = 3'd5,
    STEP_RETRY3 = 3'd6
  } step_t;

  // Reconnect commands.
  typedef enum logic [1:0] {
    REINIT_NONE    = 2'd0,
    REINIT_ENABLE  = 2'd1,
    REINIT_DISABLE = 2'd2
  } reinit_t;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_S1_TOTAL    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_S1_INTERVAL = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_S2_TOTAL    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_S2_INTERVAL = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_S3_INTERVAL = 3'd4;

  // Controller to datapath commands.
  typedef struct packed {
    logic eval;      // input transfer: run one supervisor step
    logic apply;     // remainder finished: apply the interval test
    logic out_load;  // move the finished result into the output register
  } lrb_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic need_mod;  // the step being evaluated needs the interval test
    logic rem_done;  // remainder unit finished
  } lrb_sts_t;

endpackage

`default_nettype wire

[src/link_retry_backoff_fsm.sv]
`default_nettype none

// Connection supervisor advanced by one input transfer per tick. Each transfer
// carries keys_ready and link_up and produces exactly one result transfer with
// the command pulses, the step reached and the saturating key failure count.
// Most ticks go from input transfer straight to the output phase. A retry-stage
// tick with the link down that does not escalate and whose stage interval is
// nonzero runs a bit-serial 32-bit remainder of the exception count by the
// interval, one bit per cycle, before its output phase. One tick is in work at a
// time; the next input is taken while the previous result still waits on
// out_stall. cfg_ready is always high; write configuration only while idle.

module link_retry_backoff_fsm
  import lrb_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic                 in_keys_ready,
  input  wire logic                 in_link_up,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic                      out_clear_keys,
  output logic                      out_fetch_config,
  output logic                      out_start_client,
  output logic                      out_push_keys,
  output logic [1:0]                out_reinit_cmd,
  output logic [2:0]                out_step_now,
  output logic [TALLY_W-1:0]        out_key_fail_count,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [IVL_W-1:0]     cfg_data
);

  lrb_cmd_t cmd;
  lrb_sts_t sts;

  assign cfg_ready = 1'b1;

  lrb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  lrb_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .keys_ready         (in_keys_ready),
    .link_up            (in_link_up),
    .cfg_we             (cfg_valid && cfg_ready),
    .cfg_idx            (cfg_index),
    .cfg_wdata          (cfg_data),
    .out_clear_keys     (out_clear_keys),
    .out_fetch_config   (out_fetch_config),
    .out_start_client   (out_start_client),
    .out_push_keys      (out_push_keys),
    .out_reinit_cmd     (out_reinit_cmd),
    .out_step_now       (out_step_now),
    .out_key_fail_count (out_key_fail_count)
  );

endmodule

`default_nettype wire

[src/lrb_rem.sv]
`default_nettype none

module lrb_rem
  import lrb_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [CNT_W-1:0] dividend,
  input  wire logic [IVL_W-1:0] divisor,
  output logic                  done,
  output logic                  rem_zero
);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [REM_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0]     dvd_r, dvd_nxt;
  logic [IVL_W-1:0]     div_r, div_nxt;
  logic [IVL_W-1:0]     rem_r, rem_nxt;
  logic [IVL_W:0]       trial;

  // Restoring remainder, one dividend bit per cycle.
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    div_nxt  = div_r;
    rem_nxt  = rem_r;
    trial    = {rem_r, dvd_r[CNT_W-1]};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      dvd_nxt  = dividend;
      div_nxt  = divisor;
      rem_nxt  = '0;
    end else if (busy_r) begin
      dvd_nxt = {dvd_r[CNT_W-2:0], 1'b0};
      if (trial >= {1'b0, div_r}) begin
        rem_nxt = IVL_W'(trial - {1'b0, div_r});
      end else begin
        rem_nxt = trial[IVL_W-1:0];
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == REM_CNT_W'(CNT_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    dvd_r <= dvd_nxt;
    div_r <= div_nxt;
    rem_r <= rem_nxt;
  end

  assign done     = done_r;
  assign rem_zero = (rem_r == '0);

endmodule

`default_nettype wire

[src/lrb_dp.sv]
`default_nettype none

module lrb_dp
  import lrb_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire lrb_cmd_t             cmd,
  output lrb_sts_t                  sts,
  input  wire logic                 keys_ready,
  input  wire logic                 link_up,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx,
  input  wire logic [IVL_W-1:0]     cfg_wdata,
  output logic                      out_clear_keys,
  output logic                      out_fetch_config,
  output logic                      out_start_client,
  output logic                      out_push_keys,
  output logic [1:0]                out_reinit_cmd,
  output logic [2:0]                out_step_now,
  output logic [TALLY_W-1:0]        out_key_fail_count
);

  // Configuration registers.
  logic [IVL_W-1:0] s1_total_r, s1_ivl_r, s2_total_r, s2_ivl_r, s3_ivl_r;

  // Supervisor state.
  step_t              step_r, step_nxt;
  logic [CNT_W-1:0]   exc_r, exc_nxt;
  logic               pend_r, pend_nxt;
  logic               started_r, started_nxt;
  logic [TALLY_W-1:0] tally_r, tally_nxt;

  // Per-step pulses held until the result is loaded.
  logic    clr_r, clr_nxt, fetch_r, fetch_nxt, start_r, start_nxt, push_r, push_nxt;
  reinit_t reinit_r, reinit_nxt;

  // Output register.
  logic               oclr_r, ofetch_r, ostart_r, opush_r;
  reinit_t            oreinit_r;
  step_t              ostep_r;
  logic [TALLY_W-1:0] otally_r;

  logic [CNT_W-1:0] exc_inc;
  logic [IVL_W-1:0] sel_total, sel_ivl;
  logic             has_total, escalate, need_mod;
  logic             rem_done, rem_zero;
  step_t            next_stage;

  assign exc_inc = exc_r + CNT_W'(1);

  // Stage parameters for the current retry step.
  always_comb begin
    sel_total  = s1_total_r;
    sel_ivl    = s1_ivl_r;
    has_total  = 1'b1;
    next_stage = STEP_RETRY2;
    case (step_r)
      STEP_RETRY2: begin
        sel_total  = s2_total_r;
        sel_ivl    = s2_ivl_r;
        next_stage = STEP_RETRY3;
      end
      STEP_RETRY3: begin
        sel_ivl    = s3_ivl_r;
        has_total  = 1'b0;
        next_stage = STEP_RETRY3;
      end
      default: begin
      end
    endcase
  end

  assign escalate = has_total && (exc_inc > {{(CNT_W-IVL_W){1'b0}}, sel_total});

  // One supervisor step; the interval test of a retry stage finishes later.
  always_comb begin
    step_nxt    = step_r;
    exc_nxt     = exc_r;
    pend_nxt    = pend_r;
    started_nxt = started_r;
    tally_nxt   = tally_r;
    clr_nxt     = 1'b0;
    fetch_nxt   = 1'b0;
    start_nxt   = 1'b0;
    push_nxt    = 1'b0;
    reinit_nxt  = REINIT_NONE;
    need_mod    = 1'b0;
    case (step_r)
      STEP_INIT: begin
        clr_nxt  = 1'b1;
        step_nxt = STEP_GETKEY;
      end
      STEP_GETKEY: begin
        if (keys_ready) begin
          fetch_nxt   = 1'b1;
          start_nxt   = !started_r;
          started_nxt = 1'b1;
          tally_nxt   = '0;
          step_nxt    = STEP_KEYOK;
        end else begin
          if (tally_r != TALLY_MAX) begin
            tally_nxt = tally_r + 1'b1;
          end
          step_nxt = STEP_RETRY1;
        end
      end
      STEP_KEYOK: begin
        push_nxt   = 1'b1;
        reinit_nxt = pend_r ? REINIT_ENABLE : REINIT_NONE;
        step_nxt   = STEP_CHECK;
      end
      STEP_CHECK: begin
        if (link_up) begin
          exc_nxt = '0;
          if (pend_r) begin
            pend_nxt   = 1'b0;
            reinit_nxt = REINIT_DISABLE;
          end
        end else begin
          pend_nxt = 1'b1;
          step_nxt = STEP_RETRY1;
        end
      end
      STEP_RETRY1, STEP_RETRY2, STEP_RETRY3: begin
        if (link_up) begin
          step_nxt = STEP_CHECK;
        end else begin
          exc_nxt = exc_inc;
          if (escalate) begin
            step_nxt = next_stage;
          end else begin
            need_mod = (sel_ivl != '0);
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Serial remainder of the new count by the stage interval.
  lrb_rem u_rem (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.eval && need_mod),
    .dividend (exc_inc),
    .divisor  (sel_ivl),
    .done     (rem_done),
    .rem_zero (rem_zero)
  );

  assign sts.need_mod = need_mod;
  assign sts.rem_done = rem_done;

  // State, configuration and result registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_total_r <= IVL_W'(60);
      s1_ivl_r   <= IVL_W'(10);
      s2_total_r <= IVL_W'(300);
      s2_ivl_r   <= IVL_W'(30);
      s3_ivl_r   <= IVL_W'(60);
      step_r     <= STEP_INIT;
      exc_r      <= '0;
      pend_r     <= 1'b0;
      started_r  <= 1'b0;
      tally_r    <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          CFG_S1_TOTAL:    s1_total_r <= cfg_wdata;
          CFG_S1_INTERVAL: s1_ivl_r   <= cfg_wdata;
          CFG_S2_TOTAL:    s2_total_r <= cfg_wdata;
          CFG_S2_INTERVAL: s2_ivl_r   <= cfg_wdata;
          CFG_S3_INTERVAL: s3_ivl_r   <= cfg_wdata;
          default: begin
          end
        endcase
      end
      if (cmd.eval) begin
        step_r    <= step_nxt;
        exc_r     <= exc_nxt;
        pend_r    <= pend_nxt;
        started_r <= started_nxt;
        tally_r   <= tally_nxt;
      end else if (cmd.apply && rem_zero) begin
        step_r <= STEP_INIT;
      end
    end
    if (cmd.eval) begin
      clr_r    <= clr_nxt;
      fetch_r  <= fetch_nxt;
      start_r  <= start_nxt;
      push_r   <= push_nxt;
      reinit_r <= reinit_nxt;
    end
    if (cmd.out_load) begin
      oclr_r    <= clr_r;
      ofetch_r  <= fetch_r;
      ostart_r  <= start_r;
      opush_r   <= push_r;
      oreinit_r <= reinit_r;
      ostep_r   <= step_r;
      otally_r  <= tally_r;
    end
  end

  assign out_clear_keys     = oclr_r;
  assign out_fetch_config   = ofetch_r;
  assign out_start_client   = ostart_r;
  assign out_push_keys      = opush_r;
  assign out_reinit_cmd     = oreinit_r;
  assign out_step_now       = ostep_r;
  assign out_key_fail_count = otally_r;

endmodule

`default_nettype wire

[src/lrb_ctrl.sv]
`default_nettype none

module lrb_ctrl
  import lrb_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  wire logic     out_stall,
  input  wire lrb_sts_t sts,
  output lrb_cmd_t      cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_MOD,
    S_OUT
  } ctrl_state_t;

  ctrl_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        in_xfer, out_xfer, out_free;

  assign in_stall = (state_r != S_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = out_valid_r && !out_stall;
  assign out_free = !out_valid_r || !out_stall;

  // Phase sequencing and output register occupancy.
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    if (out_xfer) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          cmd.eval  = 1'b1;
          state_nxt = sts.need_mod ? S_MOD : S_OUT;
        end
      end
      S_MOD: begin
        if (sts.rem_done) begin
          cmd.apply = 1'b1;
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

`ifndef SYNTH
  // A step that needs the interval test waits for the remainder unit.
  a_mod_entry: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && sts.need_mod |=> state_r == S_MOD)
    else $error("interval test not started after transfer");

  // The remainder unit only finishes while the controller waits for it.
  a_done_in_mod: assert property (@(posedge clk) disable iff (!rst_n)
    sts.rem_done |-> state_r == S_MOD)
    else $error("remainder finished outside its wait phase");

  // A result is never loaded over one that is still stalled.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !(out_valid_r && out_stall))
    else $error("output register overwritten while stalled");

  // Every loaded result is offered on the next cycle.
  a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_valid_r)
    else $error("loaded result not presented");
`endif

endmodule

`default_nettype wire
